@@ hdl/dasd_pkg.sv @@
package dasd_pkg;

    // Field widths of the date words
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 16;
    localparam int STATUS_W = 2;

    // Day counts from 1 January of year 0
    localparam int COUNT_W = 23;

    localparam logic [YEAR_W-1:0]   EPOCH_RESET = 14'd1970;
    localparam logic [YEAR_W-1:0]   YEAR_MIN    = 14'd1000;
    localparam logic [YEAR_W-1:0]   YEAR_MAX    = 14'd9999;
    localparam int                  MAX_OFFSET  = 65535;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DATE  = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

endpackage

@@ hdl/dasd_if.sv @@
interface dasd_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [dasd_pkg::DAY_W-1:0]          day_in;
    logic [dasd_pkg::MONTH_W-1:0]        month_in;
    logic [dasd_pkg::YEAR_W-1:0]         year_in;
    logic [dasd_pkg::OFFSET_W-1:0]       offset_days;

    modport source (output valid, action, day_in, month_in, year_in, offset_days,
                    input ready);
    modport sink   (input valid, action, day_in, month_in, year_in, offset_days,
                    output ready);
endinterface

interface dasd_out_if;
    logic                                valid;
    logic                                ready;
    logic [dasd_pkg::DAY_W-1:0]          day_out;
    logic [dasd_pkg::MONTH_W-1:0]        month_out;
    logic [dasd_pkg::YEAR_W-1:0]         year_out;
    logic [dasd_pkg::STATUS_W-1:0]       status;

    modport source (output valid, day_out, month_out, year_out, status, input ready);
    modport sink   (input valid, day_out, month_out, year_out, status, output ready);
endinterface

@@ hdl/date_add_subtract_days_unit.sv @@
// Gregorian date add/subtract unit. Each request word carries a date, an action
// (0 adds, 1 subtracts) and a day offset; the response word gives the resulting
// date and a status (0 ok, 1 invalid input date, 2 subtraction result before 1
// January of epoch_year, addition result past 31 December 9999, or offset too
// large; the date is zero whenever status is not 0). The unit is a nine stage
// pipeline: it takes one word per cycle while the response side does not stall,
// and the response word is driven from the stage 9 registers. Stages are set by
// the constant-reciprocal multiplies for the century terms and the year estimate.
// Backpressure from the response side stalls the whole pipeline.
// epoch_year is written through cfg_we/cfg_wdata and resets to 1970.
module date_add_subtract_days_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [dasd_pkg::YEAR_W-1:0] cfg_wdata,
    dasd_in_if.sink                     req,
    dasd_out_if.source                  rsp
);

    localparam int YW = dasd_pkg::YEAR_W;
    localparam int CW = dasd_pkg::COUNT_W;
    localparam logic [CW-1:0] HI_COUNT = 23'd3652425;
    localparam logic [21:0]   YEAR_RECIP = 22'd2939785;

    // floor(y / 100) by reciprocal, exact for 14-bit y
    function automatic logic [7:0] div100(input logic [YW-1:0] y);
        logic [27:0] p;
        begin
            p = 28'(y) * 28'd5243;
            return 8'(p >> 19);
        end
    endfunction

    function automatic logic [6:0] rem100(input logic [YW-1:0] y, input logic [7:0] q);
        logic [YW-1:0] t;
        begin
            t = y - 14'(14'(q) * 14'd100);
            return t[6:0];
        end
    endfunction

    // Days from 1 January of year 0 to 1 January of year y
    function automatic logic [CW-1:0] ys_calc(input logic [YW-1:0] y, input logic [7:0] q);
        logic [7:0] c;
        logic [7:0] q4;
        begin
            c  = q + 8'(rem100(y, q) != 7'd0);
            q4 = 8'((9'(c) + 9'd3) >> 2);
            return 23'(y) * 23'd365 + 23'((15'(y) + 15'd3) >> 2) - 23'(c) + 23'(q4);
        end
    endfunction

    function automatic logic leap_calc(input logic [YW-1:0] y, input logic [7:0] q);
        begin
            return (y[1:0] == 2'd0) && ((rem100(y, q) != 7'd0) || (q[1:0] == 2'd0));
        end
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        begin
            case (m)
                4'd1:    s = 9'd0;
                4'd2:    s = 9'd31;
                4'd3:    s = 9'd59;
                4'd4:    s = 9'd90;
                4'd5:    s = 9'd120;
                4'd6:    s = 9'd151;
                4'd7:    s = 9'd181;
                4'd8:    s = 9'd212;
                4'd9:    s = 9'd243;
                4'd10:   s = 9'd273;
                4'd11:   s = 9'd304;
                4'd12:   s = 9'd334;
                default: s = 9'd0;
            endcase
            return s + 9'((m > 4'd2) && leap);
        end
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                     return 5'd30;
                4'd2:                                        return leap ? 5'd29 : 5'd28;
                default:                                     return 5'd0;
            endcase
        end
    endfunction

    // Configuration register
    logic [YW-1:0] epoch_reg;

    // Stage valid bits
    logic [9:1] v_reg;
    logic       en;

    // Stage 1
    logic        s1_act_reg;
    logic [4:0]  s1_day_reg;
    logic [3:0]  s1_mon_reg;
    logic [YW-1:0] s1_year_reg;
    logic [15:0] s1_off_reg;
    logic [7:0]  s1_qy_reg, s1_qe_reg;
    logic [YW-1:0] s1_epoch_reg;
    // Stage 2
    logic        s2_act_reg;
    logic [15:0] s2_off_reg;
    logic [CW-1:0] s2_ys_reg, s2_lo_reg;
    logic [8:0]  s2_doy_reg;
    logic [1:0]  s2_st_reg;
    // Stage 3
    logic        s3_act_reg;
    logic [15:0] s3_off_reg;
    logic [CW-1:0] s3_cnt_reg, s3_lo_reg;
    logic [1:0]  s3_st_reg;
    // Stage 4
    logic [CW-1:0] s4_cnt_reg;
    logic [1:0]  s4_st_reg;
    // Stage 5
    logic [CW-1:0] s5_cnt_reg;
    logic [YW-1:0] s5_e_reg;
    logic [1:0]  s5_st_reg;
    // Stage 6
    logic [CW-1:0] s6_cnt_reg;
    logic [YW-1:0] s6_y_reg [4];
    logic [7:0]  s6_q_reg [4];
    logic [1:0]  s6_st_reg;
    // Stage 7
    logic [CW-1:0] s7_cnt_reg;
    logic [YW-1:0] s7_e_reg;
    logic [CW-1:0] s7_ys_reg [4];
    logic [1:0]  s7_st_reg;
    // Stage 8
    logic [YW-1:0] s8_y_reg;
    logic [8:0]  s8_rem_reg;
    logic        s8_leap_reg;
    logic [1:0]  s8_st_reg;
    // Stage 9 (response)
    logic [4:0]  s9_day_reg;
    logic [3:0]  s9_mon_reg;
    logic [YW-1:0] s9_year_reg;
    logic [1:0]  s9_st_reg;

    // Next values
    logic [7:0]  s1_qy_next, s1_qe_next;
    logic [CW-1:0] s2_ys_next, s2_lo_next;
    logic [8:0]  s2_doy_next;
    logic [1:0]  s2_st_next;
    logic [CW-1:0] s3_cnt_next;
    logic [CW-1:0] s4_cnt_next;
    logic [1:0]  s4_st_next;
    logic [YW-1:0] s5_e_next;
    logic [YW-1:0] s6_y_next [4];
    logic [7:0]  s6_q_next [4];
    logic [CW-1:0] s7_ys_next [4];
    logic [YW-1:0] s8_y_next;
    logic [8:0]  s8_rem_next;
    logic        s8_leap_next;
    logic [4:0]  s9_day_next;
    logic [3:0]  s9_mon_next;
    logic [YW-1:0] s9_year_next;

    // Advance the whole pipeline unless the response word is stalled
    assign en        = !v_reg[9] || rsp.ready;
    assign req.ready = en;

    // Stage 1: century quotients of the input year and the epoch
    always_comb
    begin
        s1_qy_next = div100(req.year_in);
        s1_qe_next = div100(epoch_reg);
    end

    // Stage 2: year starts of the input year and the epoch, leap rule, day of year, input check
    always_comb
    begin
        logic leap;
        logic ok;
        leap = leap_calc(s1_year_reg, s1_qy_reg);
        ok = (s1_year_reg >= dasd_pkg::YEAR_MIN) && (s1_year_reg <= dasd_pkg::YEAR_MAX)
            && (s1_mon_reg >= 4'd1) && (s1_mon_reg <= 4'd12) && (s1_day_reg != 5'd0)
            && (s1_day_reg <= month_days(s1_mon_reg, leap));
        s2_ys_next  = ys_calc(s1_year_reg, s1_qy_reg);
        s2_lo_next  = ys_calc(s1_epoch_reg, s1_qe_reg);
        s2_doy_next = month_start(s1_mon_reg, leap) + 9'(s1_day_reg) - 9'd1;
        if (!ok)
            s2_st_next = dasd_pkg::ST_BAD_DATE;
        else if (17'(s1_off_reg) > 17'(dasd_pkg::MAX_OFFSET))
            s2_st_next = dasd_pkg::ST_RANGE;
        else
            s2_st_next = dasd_pkg::ST_OK;
    end

    // Stage 3: day count of the starting date
    assign s3_cnt_next = s2_ys_reg + 23'(s2_doy_reg);

    // Stage 4: apply the offset and check the range
    always_comb
    begin
        logic [CW:0] sum;
        logic [CW:0] diff;
        logic        bad;
        sum  = {1'b0, s3_cnt_reg} + 24'(s3_off_reg);
        diff = {1'b0, s3_cnt_reg} - 24'(s3_off_reg);
        if (s3_act_reg)
        begin
            bad = (s3_cnt_reg < 23'(s3_off_reg)) || (diff[CW-1:0] < s3_lo_reg);
            s4_cnt_next = diff[CW-1:0];
        end
        else
        begin
            bad = sum >= {1'b0, HI_COUNT};
            s4_cnt_next = sum[CW-1:0];
        end
        if (s3_st_reg != dasd_pkg::ST_OK)
            s4_st_next = s3_st_reg;
        else if (bad)
            s4_st_next = dasd_pkg::ST_RANGE;
        else
            s4_st_next = dasd_pkg::ST_OK;
    end

    // Stage 5: year estimate, count * 400 / 146097
    always_comb
    begin
        logic [44:0] p;
        p = 45'(s4_cnt_reg) * 45'(YEAR_RECIP);
        s5_e_next = YW'(p >> 30);
    end

    // Stage 6: century quotients of the candidate years e-1 .. e+2
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s6_y_next[i] = s5_e_reg + YW'(i) - YW'(1);
            s6_q_next[i] = div100(s6_y_next[i]);
        end
    end

    // Stage 7: year starts of the candidates
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            s7_ys_next[i] = ys_calc(s6_y_reg[i], s6_q_reg[i]);
    end

    // Stage 8: pick the year that holds the count
    always_comb
    begin
        logic [CW-1:0] base;
        logic [CW-1:0] nxt;
        if (s7_ys_reg[1] > s7_cnt_reg)
        begin
            s8_y_next = s7_e_reg - YW'(1);
            base = s7_ys_reg[0];
            nxt  = s7_ys_reg[1];
        end
        else if (s7_ys_reg[2] <= s7_cnt_reg)
        begin
            s8_y_next = s7_e_reg + YW'(1);
            base = s7_ys_reg[2];
            nxt  = s7_ys_reg[3];
        end
        else
        begin
            s8_y_next = s7_e_reg;
            base = s7_ys_reg[1];
            nxt  = s7_ys_reg[2];
        end
        s8_rem_next  = 9'(s7_cnt_reg - base);
        s8_leap_next = (nxt - base) == 23'd366;
    end

    // Stage 9: split the day of year into month and day, zero on error
    always_comb
    begin
        logic [3:0] m;
        m = 4'd1;
        for (int i = 2; i <= 12; i++)
            if (s8_rem_reg >= month_start(4'(i), s8_leap_reg))
                m = 4'(i);
        s9_mon_next  = m;
        s9_day_next  = 5'(s8_rem_reg - month_start(m, s8_leap_reg) + 9'd1);
        s9_year_next = s8_y_reg;
        if (s8_st_reg != dasd_pkg::ST_OK)
        begin
            s9_mon_next  = 4'd0;
            s9_day_next  = 5'd0;
            s9_year_next = '0;
        end
    end

    // Hold the epoch register and the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= dasd_pkg::EPOCH_RESET;
            v_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                epoch_reg <= cfg_wdata;
            if (en)
                v_reg <= {v_reg[8:1], req.valid};
        end
    end

    // Advance the payload of every stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_act_reg   <= req.action;
            s1_day_reg   <= req.day_in;
            s1_mon_reg   <= req.month_in;
            s1_year_reg  <= req.year_in;
            s1_off_reg   <= req.offset_days;
            s1_qy_reg    <= s1_qy_next;
            s1_qe_reg    <= s1_qe_next;
            s1_epoch_reg <= epoch_reg;

            s2_act_reg <= s1_act_reg;
            s2_off_reg <= s1_off_reg;
            s2_ys_reg  <= s2_ys_next;
            s2_lo_reg  <= s2_lo_next;
            s2_doy_reg <= s2_doy_next;
            s2_st_reg  <= s2_st_next;

            s3_act_reg <= s2_act_reg;
            s3_off_reg <= s2_off_reg;
            s3_cnt_reg <= s3_cnt_next;
            s3_lo_reg  <= s2_lo_reg;
            s3_st_reg  <= s2_st_reg;

            s4_cnt_reg <= s4_cnt_next;
            s4_st_reg  <= s4_st_next;

            s5_cnt_reg <= s4_cnt_reg;
            s5_e_reg   <= s5_e_next;
            s5_st_reg  <= s4_st_reg;

            s6_cnt_reg <= s5_cnt_reg;
            s6_st_reg  <= s5_st_reg;
            for (int i = 0; i < 4; i++)
            begin
                s6_y_reg[i] <= s6_y_next[i];
                s6_q_reg[i] <= s6_q_next[i];
                s7_ys_reg[i] <= s7_ys_next[i];
            end

            s7_cnt_reg <= s6_cnt_reg;
            s7_e_reg   <= s6_y_reg[1];
            s7_st_reg  <= s6_st_reg;

            s8_y_reg    <= s8_y_next;
            s8_rem_reg  <= s8_rem_next;
            s8_leap_reg <= s8_leap_next;
            s8_st_reg   <= s7_st_reg;

            s9_day_reg  <= s9_day_next;
            s9_mon_reg  <= s9_mon_next;
            s9_year_reg <= s9_year_next;
            s9_st_reg   <= s8_st_reg;
        end
    end

    // Drive the response word
    assign rsp.valid     = v_reg[9];
    assign rsp.day_out   = s9_day_reg;
    assign rsp.month_out = s9_mon_reg;
    assign rsp.year_out  = s9_year_reg;
    assign rsp.status    = s9_st_reg;

endmodule

@@ tb/date_add_subtract_days_unit_tb.sv @@
module date_add_subtract_days_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [dasd_pkg::DAY_W-1:0]    day_t;
    typedef logic [dasd_pkg::MONTH_W-1:0]  month_t;
    typedef logic [dasd_pkg::YEAR_W-1:0]   year_t;
    typedef logic [dasd_pkg::OFFSET_W-1:0] offset_t;
    typedef logic [dasd_pkg::STATUS_W-1:0] stat_t;

    typedef struct {
        day_t   day;
        month_t month;
        year_t  year;
        stat_t  status;
    } date_word_t;

    // Predict the result date and compare it with what the unit returns
    class date_scoreboard;
        date_word_t pending[$];
        int         errors;
        int         epoch;

        function new();
            errors = 0;
            epoch  = int'(dasd_pkg::EPOCH_RESET);
        endfunction

        function bit leap(longint y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_days(int m, longint y);
            int lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (m < 1 || m > 12)
                return 0;
            if (m == 2 && leap(y))
                return 29;
            return lens[m];
        endfunction

        function longint jan_first(longint y);
            return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        endfunction

        function void note_request(bit act, int d, int m, int y, longint off);
            date_word_t w;
            longint     cnt;
            longint     yr;
            int         mo;
            w.day = '0;
            w.month = '0;
            w.year = '0;
            w.status = dasd_pkg::ST_OK;
            if (y < dasd_pkg::YEAR_MIN || y > dasd_pkg::YEAR_MAX || m < 1 || m > 12 || d < 1
                || d > month_days(m, y))
                w.status = dasd_pkg::ST_BAD_DATE;
            else if (off > dasd_pkg::MAX_OFFSET)
                w.status = dasd_pkg::ST_RANGE;
            else
            begin
                cnt = jan_first(y) + d - 1;
                for (int i = 1; i < m; i++)
                    cnt += month_days(i, y);
                if (act)
                begin
                    if (cnt < off || cnt - off < jan_first(epoch))
                        w.status = dasd_pkg::ST_RANGE;
                    else
                        cnt -= off;
                end
                else
                begin
                    cnt += off;
                    if (cnt >= jan_first(longint'(dasd_pkg::YEAR_MAX) + 1))
                        w.status = dasd_pkg::ST_RANGE;
                end
                if (w.status == dasd_pkg::ST_OK)
                begin
                    yr = cnt * 400 / 146097;
                    while (yr > 0 && jan_first(yr) > cnt)
                        yr--;
                    while (jan_first(yr + 1) <= cnt)
                        yr++;
                    cnt -= jan_first(yr);
                    mo = 1;
                    while (cnt >= month_days(mo, yr) && mo < 12)
                    begin
                        cnt -= month_days(mo, yr);
                        mo++;
                    end
                    w.day = day_t'(cnt + 1);
                    w.month = month_t'(mo);
                    w.year = year_t'(yr);
                end
            end
            pending.push_back(w);
        endfunction

        function void check_result(date_word_t got);
            date_word_t exp_w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word d=%0d m=%0d y=%0d s=%0d", $realtime,
                         got.day, got.month, got.year, got.status);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.day !== exp_w.day || got.month !== exp_w.month
                || got.year !== exp_w.year || got.status !== exp_w.status)
            begin
                $display("%0t: mismatch expected d=%0d m=%0d y=%0d s=%0d", $realtime,
                         exp_w.day, exp_w.month, exp_w.year, exp_w.status,
                         " actual d=%0d m=%0d y=%0d s=%0d",
                         got.day, got.month, got.year, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [dasd_pkg::YEAR_W-1:0] cfg_wdata;
    bit   quiet;
    date_scoreboard sb;

    dasd_in_if  req();
    dasd_out_if rsp();

    date_add_subtract_days_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    // Stall the response side in bursts and check each accepted word
    initial
    begin
        date_word_t got;
        int stall;
        rsp.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 0;
                stall = $urandom_range(1, 17);
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1;
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got.day = rsp.day_out;
                got.month = rsp.month_out;
                got.year = rsp.year_out;
                got.status = rsp.status;
                sb.check_result(got);
            end
        end
    end

    // Send one word; hold it until accepted
    task send_date(bit act, int d, int m, int y, int off);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req.valid       <= 1;
        req.action      <= act;
        req.day_in      <= day_t'(d);
        req.month_in    <= month_t'(m);
        req.year_in     <= year_t'(y);
        req.offset_days <= offset_t'(off);
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(act, d, m, y, longint'(off));
        @(negedge clk);
    endtask

    // Drain pending results, then write the epoch register
    task drain();
        req.valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task write_epoch(int val);
        drain();
        cfg_we    <= 1;
        cfg_wdata <= year_t'(val);
        @(negedge clk);
        cfg_we    <= 0;
        sb.epoch = val;
        @(negedge clk);
    endtask

    task random_date(int span);
        int y;
        int m;
        int d;
        int off;
        if ($urandom_range(0, 9) == 0)
            send_date($urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 15),
                      $urandom_range(0, 16383), $urandom_range(0, 65535));
        else
        begin
            y = $urandom_range(0, 3) == 0 ? $urandom_range(1000, 9999)
                                          : $urandom_range(sb.epoch, sb.epoch + span);
            if (y > 9999)
                y = 9999;
            m = $urandom_range(1, 12);
            d = $urandom_range(1, sb.month_days(m, y) + ($urandom_range(0, 15) == 0));
            off = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 800);
            send_date($urandom_range(0, 1), d, m, y, off);
        end
    endtask

    initial
    begin
        int epochs[4] = '{1000, 9999, 2000, 1583};
        sb = new();
        quiet = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        req.valid = 0;
        req.action = 0;
        req.day_in = 0;
        req.month_in = 0;
        req.year_in = 0;
        req.offset_days = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, leap rules, invalid dates, range limits
        send_date(0, 1, 1, 1970, 0);
        send_date(1, 1, 1, 1970, 0);
        send_date(1, 1, 1, 1970, 1);
        send_date(0, 31, 12, 9999, 0);
        send_date(0, 31, 12, 9999, 1);
        send_date(0, 28, 2, 2000, 1);
        send_date(0, 28, 2, 1900, 1);
        send_date(0, 29, 2, 1900, 0);
        send_date(0, 29, 2, 2024, 365);
        send_date(1, 1, 3, 2100, 1);
        send_date(0, 0, 5, 2000, 3);
        send_date(0, 32 - 1, 4, 2000, 3);
        send_date(0, 1, 0, 2000, 3);
        send_date(0, 1, 13, 2000, 3);
        send_date(0, 1, 15, 2000, 3);
        send_date(0, 1, 1, 999, 3);
        send_date(0, 1, 1, 16383, 3);
        send_date(0, 1, 1, 1500, 65535);
        send_date(1, 1, 1, 1500, 5);
        send_date(1, 31, 12, 9999, 65535);
        send_date(0, 15, 6, 9900, 65535);
        send_date(0, 31, 1, 2023, 28);

        // Random phases over several epochs, with extremes
        foreach (epochs[k])
        begin
            write_epoch(epochs[k]);
            send_date(1, 1, 1, epochs[k], 0);
            send_date(1, 1, 1, epochs[k], 1);
            for (int i = 0; i < 200; i++)
                random_date(400);
        end
        write_epoch(int'(dasd_pkg::EPOCH_RESET));
        for (int i = 0; i < 150; i++)
            random_date(300);
        quiet = 1;
        for (int i = 0; i < 100; i++)
            random_date(300);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
